/* rtl/hsp_pkg.sv */
// shared types, constants and the hall transition classifier
package hsp_pkg;

  localparam int HALL_W       = 3;
  localparam int SEQ_W        = 18;
  localparam int TIMEOUT_W    = 21;
  localparam int NUM_W        = 24;
  localparam int POS_W        = 32;
  localparam int PERIOD_OUT_W = 21;
  localparam int SPEED_W      = 24;
  localparam int KIND_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int SEQ_LEN      = 6;

  localparam logic [PERIOD_OUT_W-1:0] PERIOD_OUT_MAX = 21'h1FFFFF;

  // register reset values
  localparam logic [SEQ_W-1:0]     SEQ_RST       = 18'd183449;
  localparam logic                 REVERSE_RST   = 1'b0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 21'd1000000;
  localparam logic [NUM_W-1:0]     NUM_RST       = 24'd2500000;
  localparam logic [POS_W-1:0]     POS_START_RST = 32'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALL_SEQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_START = 3'd4;

  // edge kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_JUMP = 2'd3;

  // transition direction against the sequence
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0]     hall_sequence;
    logic                 reverse_count;
    logic [TIMEOUT_W-1:0] stall_timeout;
  } hsp_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic [PERIOD_OUT_W-1:0] period_out;
    logic                    stalled;
    logic [KIND_W-1:0]       kind;
  } hsp_item_t;

  // forward match is tested first, so a change matching both ways is forward
  function automatic logic [1:0] hsp_classify(input logic [SEQ_W-1:0]  seq,
                                              input logic [HALL_W-1:0] from_code,
                                              input logic [HALL_W-1:0] to_code);
    logic fwd;
    logic bwd;
    fwd = 1'b0;
    bwd = 1'b0;
    for (int k = 0; k < SEQ_LEN; k++) begin
      if (to_code == seq[HALL_W*k +: HALL_W] &&
          from_code == seq[HALL_W*((k + SEQ_LEN - 1) % SEQ_LEN) +: HALL_W])
        fwd = 1'b1;
      if (to_code == seq[HALL_W*k +: HALL_W] &&
          from_code == seq[HALL_W*((k + 1) % SEQ_LEN) +: HALL_W])
        bwd = 1'b1;
    end
    if (fwd)
      return DIR_FWD;
    else if (bwd)
      return DIR_BWD;
    else
      return DIR_NONE;
  endfunction

endpackage

/* rtl/hsp_front.sv */
// sample intake: edge detect, position count, period and stall tracking
module hsp_front #(
  parameter int PERIOD_BITS = 21
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hsp_pkg::hsp_cfg_t                   cfg,
  input  logic                                pos_load,
  input  logic [hsp_pkg::POS_W-1:0]           pos_value,
  input  logic                                accept,
  input  logic [hsp_pkg::HALL_W-1:0]          hall_code,
  output hsp_pkg::hsp_item_t                  item,
  output logic [PERIOD_BITS-1:0]              divisor
);
  import hsp_pkg::*;

  localparam int CMP_W = (PERIOD_BITS > TIMEOUT_W) ? PERIOD_BITS : TIMEOUT_W;

  logic [HALL_W-1:0]      prev_r, prev_nxt;
  logic [POS_W-1:0]       step_r, step_nxt;
  logic [PERIOD_BITS-1:0] ticks_r, ticks_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic                   stall_r, stall_nxt;
  logic [PERIOD_BITS-1:0] elapsed;
  logic                   change;
  logic [1:0]             dir;
  logic                   up;
  logic [KIND_W-1:0]      kind;
  logic [CMP_W-1:0]       period_ext;

  always_comb begin
    elapsed    = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;
    change     = hall_code != prev_r;
    dir        = hsp_classify(cfg.hall_sequence, prev_r, hall_code);
    up         = (dir == DIR_FWD) != cfg.reverse_count;
    prev_nxt   = hall_code;
    step_nxt   = step_r;
    kind       = KIND_NONE;
    ticks_nxt  = elapsed;
    period_nxt = period_r;
    stall_nxt  = stall_r;
    if (change) begin
      ticks_nxt  = '0;
      period_nxt = elapsed;
      stall_nxt  = 1'b0;
      if (dir == DIR_NONE) begin
        kind = KIND_JUMP;
      end else if (up) begin
        step_nxt = step_r + 1'b1;
        kind     = KIND_UP;
      end else begin
        step_nxt = step_r - 1'b1;
        kind     = KIND_DOWN;
      end
    end
    if (CMP_W'(ticks_nxt) >= CMP_W'(cfg.stall_timeout))
      stall_nxt = 1'b1;
    period_ext = CMP_W'(period_nxt);
  end

  always_comb begin
    item.position   = step_nxt;
    item.period_out = (period_ext > CMP_W'(PERIOD_OUT_MAX)) ? PERIOD_OUT_MAX
                                                            : period_ext[PERIOD_OUT_W-1:0];
    item.stalled    = stall_nxt;
    item.kind       = kind;
    divisor         = period_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      step_r   <= POS_START_RST;
      ticks_r  <= '0;
      period_r <= PERIOD_BITS'(1);
      stall_r  <= 1'b1;
    end else if (pos_load) begin
      step_r <= pos_value;
    end else if (accept) begin
      prev_r   <= prev_nxt;
      step_r   <= step_nxt;
      ticks_r  <= ticks_nxt;
      period_r <= period_nxt;
      stall_r  <= stall_nxt;
    end
  end

endmodule

/* rtl/hsp_queue.sv */
// small register queue between intake and speed divider
module hsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)
      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      slot_r[wr_ptr_r] <= wdata;
  end

endmodule

/* rtl/hsp_back.sv */
// speed divider (one quotient bit per cycle) and result register
module hsp_back #(
  parameter int PERIOD_BITS = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hsp_pkg::NUM_W-1:0]         rpm_numerator,
  input  logic                              q_empty,
  input  hsp_pkg::hsp_item_t                q_item,
  input  logic [PERIOD_BITS-1:0]            q_divisor,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [hsp_pkg::POS_W-1:0]         out_position_count,
  output logic [hsp_pkg::SPEED_W-1:0]       out_speed_rpm,
  output logic [hsp_pkg::PERIOD_OUT_W-1:0]  out_period_ticks,
  output logic                              out_stalled,
  output logic [hsp_pkg::KIND_W-1:0]        out_edge_kind
);
  import hsp_pkg::*;

  localparam int CNT_W = $clog2(SPEED_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  hsp_item_t              item_r, item_nxt;
  logic [PERIOD_BITS-1:0] div_r, div_nxt;
  logic [PERIOD_BITS-1:0] rem_r, rem_nxt;
  logic [SPEED_W-1:0]     quot_r, quot_nxt;
  logic [PERIOD_BITS:0]   shifted;
  logic [PERIOD_BITS:0]   diff;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;

  // quot_r holds the dividend bits still to shift in, quotient bits fill from the bottom
  assign shifted = {rem_r, quot_r[SPEED_W-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    item_nxt  = item_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          div_nxt  = q_divisor;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (q_item.stalled || q_divisor == '0) begin
            quot_nxt  = '0;
            state_nxt = ST_DONE;
          end else begin
            quot_nxt  = rpm_numerator;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!diff[PERIOD_BITS]) begin
          rem_nxt  = diff[PERIOD_BITS-1:0];
          quot_nxt = {quot_r[SPEED_W-2:0], 1'b1};
        end else begin
          rem_nxt  = shifted[PERIOD_BITS-1:0];
          quot_nxt = {quot_r[SPEED_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SPEED_W - 1))
          state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)
      out_valid_nxt = 1'b1;
    else if (out_pop)
      out_valid_nxt = 1'b0;
  end

  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (out_load) begin
      out_position_count <= item_r.position;
      out_speed_rpm      <= quot_r;
      out_period_ticks   <= item_r.period_out;
      out_stalled        <= item_r.stalled;
      out_edge_kind      <= item_r.kind;
    end
  end

endmodule

/* rtl/hall_sensor_position_speed.sv */
// top level: hall sensor position counter and speed estimator
//
// Input channel: one 3-bit hall sample per tick on in_hall_code, taken when
// in_push is high and in_full is low. Every sample yields exactly one result.
// Result channel: while out_empty is low the oldest result sits on the out_
// ports (position count, speed in rpm, last period, stall flag, edge kind);
// it leaves when out_pop is high.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at once;
// index 0 hall sequence, 1 reverse, 2 stall timeout, 3 rpm numerator,
// 4 position start (reloads the position count; no register keeps it).
// Timing: the intake updates position, period and stall state in the cycle
// a sample is taken and queues the result. The speed divider produces one
// quotient bit per cycle; the back end takes a new item from the queue only
// after the last one has been loaded into the result register. A stalled item
// or a zero period skips the divide and yields speed zero. A two-entry
// queue lets samples enter while the divider works.
// Reset (rst_n low, synchronous) loads register defaults, position start,
// period one and stall set, and empties queue and result register.
// If the receiver stops popping, the result register holds, the divider
// waits, the queue fills and in_full rises; nothing is dropped.
module hall_sensor_position_speed #(
  parameter int PERIOD_BITS = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [hsp_pkg::HALL_W-1:0]        in_hall_code,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [hsp_pkg::POS_W-1:0]         out_position_count,
  output logic [hsp_pkg::SPEED_W-1:0]       out_speed_rpm,
  output logic [hsp_pkg::PERIOD_OUT_W-1:0]  out_period_ticks,
  output logic                              out_stalled,
  output logic [hsp_pkg::KIND_W-1:0]        out_edge_kind,
  input  logic                              cfg_we,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import hsp_pkg::*;

  localparam int ENTRY_W = $bits(hsp_item_t) + PERIOD_BITS;

  logic [SEQ_W-1:0]       seq_r;
  logic                   reverse_r;
  logic [TIMEOUT_W-1:0]   timeout_r;
  logic [NUM_W-1:0]       num_r;
  hsp_cfg_t               cfg;
  logic                   pos_load;
  logic                   accept;
  hsp_item_t              f_item;
  logic [PERIOD_BITS-1:0] f_divisor;
  logic [ENTRY_W-1:0]     q_rdata;
  logic                   q_empty;
  logic                   q_pop;
  hsp_item_t              q_item;
  logic [PERIOD_BITS-1:0] q_divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SEQ_RST;
      reverse_r <= REVERSE_RST;
      timeout_r <= TIMEOUT_RST;
      num_r     <= NUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALL_SEQ:  seq_r     <= cfg_wdata[SEQ_W-1:0];
        CFG_REVERSE:   reverse_r <= cfg_wdata[0];
        CFG_TIMEOUT:   timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_NUMERATOR: num_r     <= cfg_wdata[NUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.hall_sequence = seq_r;
  assign cfg.reverse_count = reverse_r;
  assign cfg.stall_timeout = timeout_r;
  assign pos_load          = cfg_we && cfg_index == CFG_POS_START;
  assign accept            = in_push && !in_full;

  hsp_front #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .pos_load (pos_load),
    .pos_value(cfg_wdata[POS_W-1:0]),
    .accept   (accept),
    .hall_code(in_hall_code),
    .item     (f_item),
    .divisor  (f_divisor)
  );

  hsp_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (accept),
    .wdata({f_item, f_divisor}),
    .full (in_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign q_item    = q_rdata[ENTRY_W-1:PERIOD_BITS];
  assign q_divisor = q_rdata[PERIOD_BITS-1:0];

  hsp_back #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rpm_numerator     (num_r),
    .q_empty           (q_empty),
    .q_item            (q_item),
    .q_divisor         (q_divisor),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_position_count(out_position_count),
    .out_speed_rpm     (out_speed_rpm),
    .out_period_ticks  (out_period_ticks),
    .out_stalled       (out_stalled),
    .out_edge_kind     (out_edge_kind)
  );

  // a stalled result never carries a speed
  a_stall_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_stalled |-> out_speed_rpm == '0)
    else $error("stalled result with nonzero speed");

  // a latched period is at least one tick
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_period_ticks != '0)
    else $error("result with zero period");

  // the divider only takes items that are queued
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("divider popped an empty queue");

  // an accepted sample always lands in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !q_empty)
    else $error("accepted item missing from queue");

endmodule
